FILE: hw/rtl/btpc_pkg.sv
// Package for the barometric compensation unit: queue sizes, item types,
// register indexes and shared arithmetic helpers. Depends on nothing.
package btpc_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;
    localparam int unsigned AddrW      = 5;

    typedef enum logic [1:0] {
        REG_TEMP   = 2'd0,
        REG_PLOW   = 2'd1,
        REG_PHIGH  = 2'd2,
        REG_PNINE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } t_in_item;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] press_pa;
        logic        press_valid;
    } t_out_item;

    // Temperature results and the pressure-side values handed to the back end.
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] pvar1;
        logic [31:0] pvar2;
        logic [19:0] raw_press;
    } t_mid_item;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

FILE: hw/rtl/btpc_if.sv
// Valid/ready channel interface carrying one request of a generic payload type.
// Depends on nothing; instances choose the payload type.
interface btpc_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/btpc_ram.sv
// Generic single-write, registered-read RAM used for the decoupling queue.
// Depends on nothing.
module btpc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/btpc_front.sv
// Front end: accepts raw pairs and computes the temperature chain and the two
// pressure intermediates in a pipeline. Depends on btpc_pkg.
module btpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [47:0]          i_tc,
    input  logic [63:0]          i_pl,
    input  logic [63:0]          i_ph,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  btpc_pkg::t_in_item   i_in,
    output logic                 o_mid_valid,
    input  logic                 i_mid_ready,
    output btpc_pkg::t_mid_item  o_mid
);
    // Six stages, each with at most one 32-bit multiply between registers.
    localparam int unsigned NStg = 6;

    logic [NStg-1:0] r_vld;
    logic            w_adv;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    assign t1 = {16'd0, i_tc[15:0]};
    assign t2 = btpc_pkg::sx16(i_tc[31:16]);
    assign t3 = btpc_pkg::sx16(i_tc[47:32]);
    assign p1 = {16'd0, i_pl[15:0]};
    assign p2 = btpc_pkg::sx16(i_pl[31:16]);
    assign p3 = btpc_pkg::sx16(i_pl[47:32]);
    assign p4 = btpc_pkg::sx16(i_pl[63:48]);
    assign p5 = btpc_pkg::sx16(i_ph[15:0]);
    assign p6 = btpc_pkg::sx16(i_ph[31:16]);

    // Whole pipe advances together; it stalls only when its tail is held.
    assign w_adv      = !(r_vld[NStg-1] && !i_mid_ready);
    assign o_in_ready = w_adv;

    logic [19:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    // Stage 1
    logic [31:0] r_a1, r_dd1, r_x1;
    // Stage 2
    logic [31:0] r_a2, r_b2;
    // Stage 3
    logic [31:0] r_fine3, r_tcm3, r_pa3, r_qq3;
    // Stage 4
    logic [31:0] r_fine4, r_tc4, r_pa4, r_v6, r_v5, r_v3, r_v2;
    // Stage 5
    logic [31:0] r_fine5, r_tc5, r_b5, r_a5, r_v25;
    // Stage 6
    logic [31:0] r_fine6, r_tc6, r_b6, r_a6;

    logic [31:0] w_d0, w_pa, w_q, w_a5;
    assign w_d0 = {16'd0, i_in.raw_temp[19:4]} - t1;
    assign w_pa = btpc_pkg::asr(r_fine3, 5'd1) - 32'd64000;
    assign w_q  = btpc_pkg::asr(w_pa, 5'd2);
    assign w_a5 = btpc_pkg::asr(btpc_pkg::asr(r_v3, 5'd3) + btpc_pkg::asr(r_v2, 5'd1),
                                5'd18);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NStg-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p0    <= i_in.raw_press;
            r_a1    <= ({15'd0, i_in.raw_temp[19:3]} - (t1 << 1)) * t2;
            r_dd1   <= w_d0 * w_d0;
            r_x1    <= '0;
            r_p1    <= r_p0;
            r_a2    <= btpc_pkg::asr(r_a1, 5'd11);
            r_b2    <= btpc_pkg::asr(r_dd1, 5'd12) * t3;
            r_p2    <= r_p1;
            r_fine3 <= r_a2 + btpc_pkg::asr(r_b2, 5'd14);
            r_tcm3  <= '0;
            r_pa3   <= '0;
            r_qq3   <= '0;
            r_p3    <= r_p2;
            r_fine4 <= r_fine3;
            r_tc4   <= btpc_pkg::asr(r_fine3 * 32'd5 + 32'd128, 5'd8);
            r_pa4   <= w_pa;
            r_v6    <= btpc_pkg::asr(w_q * w_q, 5'd11);
            r_v3    <= btpc_pkg::asr(w_q * w_q, 5'd13);
            r_v5    <= w_pa * p5;
            r_v2    <= p2 * w_pa;
            r_p4    <= r_p3;
            r_fine5 <= r_fine4;
            r_tc5   <= r_tc4;
            r_b5    <= btpc_pkg::asr(r_v6 * p6 + (r_v5 << 1), 5'd2) + (p4 << 16);
            r_a5    <= p3 * r_v3;
            r_v25   <= r_v2;
            r_p5    <= r_p4;
            r_fine6 <= r_fine5;
            r_tc6   <= r_tc5;
            r_b6    <= r_b5;
            r_a6    <= btpc_pkg::asr((32'd32768 + btpc_pkg::asr(btpc_pkg::asr(r_a5, 5'd3)
                                     + btpc_pkg::asr(r_v25, 5'd1), 5'd18))
                                     * p1, 5'd15);
        end
    end

    assign o_mid_valid         = r_vld[NStg-1];
    assign o_mid.temp_centi    = r_tc6;
    assign o_mid.fine_temp     = r_fine6;
    assign o_mid.pvar1         = r_a6;
    assign o_mid.pvar2         = r_b6;
    assign o_mid.raw_press     = r_p5;

    logic w_unused;
    assign w_unused = ^{r_x1, r_tcm3, r_pa3, r_qq3, w_a5, r_a2[0], r_pa4, i_ph[63:32]};

    property p_fine_tc;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[2] |=> r_tc4 == btpc_pkg::asr($past(r_fine3) * 32'd5 + 32'd128, 5'd8);
    endproperty
    a_fine_tc: assert property (p_fine_tc) else $error("temperature stage mismatch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld)) else $error("pipe moved while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NStg-1] |-> o_in_ready) else $error("front stalled with empty tail");
endmodule

FILE: hw/rtl/btpc_back.sv
// Back end: restoring 32-bit division, one quotient bit per stage, then the
// second-order pressure correction. Depends on btpc_pkg.
module btpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [63:0]          i_ph,
    input  logic [15:0]          i_p9,
    input  logic                 i_mid_valid,
    output logic                 o_mid_ready,
    input  btpc_pkg::t_mid_item  i_mid,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output btpc_pkg::t_out_item  o_out
);
    // 2 prep stages, 32 divider stages, 3 correction stages.
    localparam int unsigned NDiv = 32;
    localparam int unsigned NStg = NDiv + 5;
    localparam int unsigned SQ   = NDiv + 2;

    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] fine;
        logic [31:0] dvs;
        logic [31:0] num;
        logic [31:0] quo;
        logic [32:0] rem;
        logic        big;
        logic [31:0] x;
        logic [31:0] y;
    } t_stg;

    logic [31:0] p7, p8, p9;
    assign p7 = btpc_pkg::sx16(i_ph[47:32]);
    assign p8 = btpc_pkg::sx16(i_ph[63:48]);
    assign p9 = btpc_pkg::sx16(i_p9);

    logic [NStg-1:0] r_vld;
    t_stg            r_s [NStg];
    t_stg            n_s [NStg];
    logic            w_adv;

    assign w_adv       = !(r_vld[NStg-1] && !i_out_ready);
    assign o_mid_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NStg-2:0], i_mid_valid};
        end
    end

    logic [31:0] w_press, w_p3;
    assign w_press = r_s[SQ-1].big ? (r_s[SQ-1].quo << 1) : r_s[SQ-1].quo;
    assign w_p3    = {3'd0, w_press[31:3]};

    always_comb begin
        logic [32:0] sh;
        logic [32:0] df;
        // Stage 0: numerator product.
        n_s[0]      = '0;
        n_s[0].tc   = i_mid.temp_centi;
        n_s[0].fine = i_mid.fine_temp;
        n_s[0].dvs  = i_mid.pvar1;
        n_s[0].num  = (32'd1048576 - {12'd0, i_mid.raw_press}
                       - btpc_pkg::asr(i_mid.pvar2, 5'd12)) * 32'd3125;

        // Stage 1: choose dividend form by the split at 0x80000000.
        n_s[1]     = r_s[0];
        n_s[1].big = r_s[0].num[31];
        n_s[1].num = r_s[0].num[31] ? r_s[0].num : (r_s[0].num << 1);

        // Divider stages: one quotient bit each, MSB first.
        for (int k = 0; k < NDiv; k++) begin
            sh = {r_s[k+1].rem[31:0], r_s[k+1].num[31-k]};
            df = sh - {1'b0, r_s[k+1].dvs};
            n_s[k+2] = r_s[k+1];
            if (!df[32]) begin
                n_s[k+2].rem = df;
                n_s[k+2].quo = {r_s[k+1].quo[30:0], 1'b1};
            end else begin
                n_s[k+2].rem = sh;
                n_s[k+2].quo = {r_s[k+1].quo[30:0], 1'b0};
            end
        end

        // Correction stages.
        n_s[SQ]       = r_s[SQ-1];
        n_s[SQ].quo   = w_press;
        n_s[SQ].x     = (w_p3 * w_p3) >> 13;
        n_s[SQ].y     = {2'd0, w_press[31:2]} * p8;
        n_s[SQ+1]     = r_s[SQ];
        n_s[SQ+1].x   = btpc_pkg::asr(p9 * r_s[SQ].x, 5'd12);
        n_s[SQ+1].y   = btpc_pkg::asr(r_s[SQ].y, 5'd13);
        n_s[SQ+2]     = r_s[SQ+1];
        n_s[SQ+2].quo = r_s[SQ+1].quo
                        + btpc_pkg::asr(r_s[SQ+1].x + r_s[SQ+1].y + p7, 5'd4);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s <= n_s;
        end
    end

    logic w_ok;
    assign w_ok              = r_s[NStg-1].dvs != '0;
    assign o_out_valid       = r_vld[NStg-1];
    assign o_out.temp_centi  = r_s[NStg-1].tc;
    assign o_out.fine_temp   = r_s[NStg-1].fine;
    assign o_out.press_pa    = w_ok ? r_s[NStg-1].quo : '0;
    assign o_out.press_valid = w_ok;

    logic w_unused;
    assign w_unused = ^{i_ph[31:0]};

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.press_valid |-> o_out.press_pa == '0)
        else $error("invalid pressure not zero");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld)) else $error("back pipe moved while stalled");

    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQ-1] && r_s[SQ-1].dvs != '0 |-> r_s[SQ-1].rem < {1'b0, r_s[SQ-1].dvs})
        else $error("divider remainder out of range");
endmodule

FILE: hw/rtl/btpc_fifo.sv
// Short request queue between front and back ends, built on the generic RAM
// with a registered read and a one-entry output stage. Depends on btpc_pkg, btpc_ram.
module btpc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  btpc_pkg::t_mid_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output btpc_pkg::t_mid_item  o_data
);
    localparam int unsigned W  = $bits(btpc_pkg::t_mid_item);
    localparam int unsigned PW = btpc_pkg::QueuePtrW;

    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          r_ov;
    logic [W-1:0]  w_rd;
    logic          w_push, w_pop, w_load;

    // RAM holds entries not yet loaded into the output stage.
    assign o_ready = r_cnt != (PW+1)'(btpc_pkg::QueueDepth);
    assign w_push  = i_valid && o_ready;
    assign w_load  = (r_cnt != '0) && (!o_valid || i_ready);
    assign w_pop   = o_valid && i_ready;

    btpc_ram #(.Width(W), .Depth(btpc_pkg::QueueDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_push),
        .i_waddr(r_wp),
        .i_wdata(i_data),
        .i_raddr(r_rp),
        .o_rdata(w_rd)
    );

    // The output valid r_ov is set in the cycle after a read and marks read data ready.
    // Read data is shown only in the cycle after a load; after that the
    // output stage r_hd keeps the request steady while it waits.
    logic r_fresh;
    btpc_pkg::t_mid_item r_hd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_ov <= 1'b0; r_fresh <= 1'b0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_load) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_load);
            if (w_load)      r_ov <= 1'b1;
            else if (w_pop)  r_ov <= 1'b0;
            r_fresh <= w_load;
        end
    end
    always_ff @(posedge i_clk) begin
        r_hd <= o_data;
    end
    assign o_valid = r_ov;
    assign o_data  = r_fresh ? btpc_pkg::t_mid_item'(w_rd) : r_hd;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(btpc_pkg::QueueDepth)) else $error("queue overfill");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_wp == r_rp) else $error("queue pointers diverged");
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_rp) && $stable(o_data))
        else $error("queue output dropped");
endmodule

FILE: hw/rtl/baro_temp_pressure_compensation_unit.sv
// Top level of the barometric compensation unit: configuration registers,
// front end, request queue and back end. Depends on btpc_pkg, btpc_if and submodules.
//
//  channel   | dir | payload                                   | handshake
//  ----------+-----+-------------------------------------------+-------------
//  in_ch     | in  | raw_temp[19:0], raw_press[19:0]           | valid/ready
//  out_ch    | out | temp_centi, fine_temp, press_pa, valid    | valid/ready
//  apb       | in  | coefficient registers at 8*i, 64-bit data | psel/penable
//
// One request enters per cycle when nothing stalls. A request passes through the
// front pipeline, the queue and the back end, whose length is set by the restoring
// divider that resolves one quotient bit per stage.
// Reset is synchronous, active low, and clears valid flags and coefficient registers.
// A held output stalls the back end; the front runs on until the queue is full.
module baro_temp_pressure_compensation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    btpc_if.sink                           i_in,
    btpc_if.source                         o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btpc_pkg::AddrW-1:0]     paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);
    logic [47:0] r_tc;
    logic [63:0] r_pl, r_ph;
    logic [15:0] r_p9;
    logic [1:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0; r_pl <= '0; r_ph <= '0; r_p9 <= '0;
        end else if (w_wr) begin
            unique case (btpc_pkg::t_reg_idx'(w_idx))
                btpc_pkg::REG_TEMP:  r_tc <= pwdata[47:0];
                btpc_pkg::REG_PLOW:  r_pl <= pwdata;
                btpc_pkg::REG_PHIGH: r_ph <= pwdata;
                btpc_pkg::REG_PNINE: r_p9 <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (btpc_pkg::t_reg_idx'(w_idx))
            btpc_pkg::REG_TEMP:  prdata = {16'd0, r_tc};
            btpc_pkg::REG_PLOW:  prdata = r_pl;
            btpc_pkg::REG_PHIGH: prdata = r_ph;
            btpc_pkg::REG_PNINE: prdata = {48'd0, r_p9};
            default:             prdata = '0;
        endcase
    end

    logic                 w_fv, w_fr, w_bv, w_br;
    btpc_pkg::t_mid_item  w_fd, w_bd;

    btpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tc(r_tc), .i_pl(r_pl), .i_ph(r_ph),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready), .i_in(i_in.data),
        .o_mid_valid(w_fv), .i_mid_ready(w_fr), .o_mid(w_fd)
    );

    btpc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fd),
        .o_valid(w_bv), .i_ready(w_br), .o_data(w_bd)
    );

    btpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ph(r_ph), .i_p9(r_p9),
        .i_mid_valid(w_bv), .o_mid_ready(w_br), .i_mid(w_bd),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready), .o_out(o_out.data)
    );

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && w_idx == btpc_pkg::REG_PNINE |=> r_p9 == $past(pwdata[15:0]))
        else $error("coefficient nine write lost");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_tc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && w_idx == btpc_pkg::REG_TEMP |=> r_tc == $past(pwdata[47:0]))
        else $error("temperature coefficient write lost");
endmodule
